// File: hw/rtl/chist_pkg.sv
// Package for the distinct-color histogram table: sizes, item types and codes.
// Used by color_histogram_table_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package chist_pkg;

  localparam int unsigned MAX_COLORS     = 256;
  localparam int unsigned COMPONENT_BITS = 16;

  localparam int unsigned SLOT_W = $clog2(MAX_COLORS);
  localparam int unsigned USED_W = $clog2(MAX_COLORS + 1);
  localparam int unsigned COMP_W = 16;
  localparam int unsigned COLOR_W = 3 * COMP_W;
  localparam int unsigned TALLY_W = 32;

  localparam logic [COMP_W-1:0] COMP_MASK = COMP_W'((64'd1 << COMPONENT_BITS) - 64'd1);

  typedef enum logic [1:0] {
    REQ_TALLY  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [7:0]        position;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               dropped;
    logic [7:0]         entry_pos;
    logic [COMP_W-1:0]  out_red;
    logic [COMP_W-1:0]  out_green;
    logic [COMP_W-1:0]  out_blue;
    logic [TALLY_W-1:0] use_count;
    logic [8:0]         distinct;
  } rsp_t;

  function automatic logic [COLOR_W-1:0] pack_color(input req_t r);
    return {r.red & COMP_MASK, r.green & COMP_MASK, r.blue & COMP_MASK};
  endfunction

  function automatic rsp_t make_rsp(input logic hit, input logic dropped,
                                    input logic [7:0] pos, input logic [COLOR_W-1:0] col,
                                    input logic [TALLY_W-1:0] cnt, input logic [8:0] n_used);
    rsp_t r;
    r.hit       = hit;
    r.dropped   = dropped;
    r.entry_pos = pos;
    r.out_red   = col[3*COMP_W-1:2*COMP_W];
    r.out_green = col[2*COMP_W-1:COMP_W];
    r.out_blue  = col[COMP_W-1:0];
    r.use_count = cnt;
    r.distinct  = n_used;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/color_histogram_table_top.sv
// Distinct-color histogram table: color and count memories, scan sequencer,
// result register. Depends on chist_pkg.
`timescale 1ns / 1ps
`default_nettype none

// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | in_data_i  (chist_pkg::req_t)
// out     | out_valid_o| out_stall_i | out_data_o (chist_pkg::rsp_t)
//
// A tally or lookup scans the color memory newest first, one entry per cycle,
// until it finds the color or has checked every stored entry.
// A read of a stored position passes through S_READ to S_DONE; an empty table, a
// read past the end or an unused code goes straight to S_DONE.
// Reset clears the entry count and control state, not the memories; they need no clearing pass.
// The next item is taken while a result waits on a stalled output.

module color_histogram_table_top (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  chist_pkg::req_t      in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output chist_pkg::rsp_t      out_data_o
);

  logic [chist_pkg::COLOR_W-1:0] color_mem [chist_pkg::MAX_COLORS];
  logic [chist_pkg::TALLY_W-1:0] tally_mem [chist_pkg::MAX_COLORS];

  chist_pkg::state_e state_q, state_d;
  logic [chist_pkg::USED_W-1:0] used_q, used_d;
  logic [chist_pkg::SLOT_W-1:0] scan_q, scan_d;
  logic [chist_pkg::SLOT_W-1:0] chk_slot_q, chk_slot_d;
  logic more_q, more_d;
  logic chk_q, chk_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] req_q;
  logic [chist_pkg::COLOR_W-1:0] col_q;
  logic [7:0] pos_q;
  chist_pkg::rsp_t res_q, res_d;
  chist_pkg::rsp_t out_q;

  logic [chist_pkg::COLOR_W-1:0] rd_color_q;
  logic [chist_pkg::TALLY_W-1:0] rd_tally_q;
  logic [chist_pkg::SLOT_W-1:0] rd_addr, wr_addr;
  logic color_we, tally_we;
  logic [chist_pkg::COLOR_W-1:0] wr_color;
  logic [chist_pkg::TALLY_W-1:0] wr_tally;

  logic acc, out_free, hit_s, scan_end, pos_ok, tbl_empty, add_new;
  logic [chist_pkg::COLOR_W-1:0] in_col, new_col;
  logic [chist_pkg::TALLY_W-1:0] sat_tally;
  logic [chist_pkg::USED_W-1:0] match_pos;

  assign acc        = in_valid_i && (state_q == chist_pkg::S_IDLE);
  assign in_stall_o = (state_q != chist_pkg::S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_col     = chist_pkg::pack_color(in_data_i);
  assign tbl_empty  = (used_q == '0);
  assign pos_ok     = (32'(in_data_i.position) < 32'(used_q));
  assign hit_s      = chk_q && (rd_color_q == col_q);
  assign scan_end   = chk_q && !hit_s && !more_q;
  assign sat_tally  = (rd_tally_q == '1) ? rd_tally_q : rd_tally_q + 32'd1;
  assign match_pos  = used_q - chist_pkg::USED_W'(1) - chist_pkg::USED_W'(chk_slot_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      chist_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.req_type)
            chist_pkg::REQ_TALLY, chist_pkg::REQ_LOOKUP: begin
              state_d = tbl_empty ? chist_pkg::S_DONE : chist_pkg::S_SCAN;
            end
            chist_pkg::REQ_READ: begin
              state_d = pos_ok ? chist_pkg::S_READ : chist_pkg::S_DONE;
            end
            default: state_d = chist_pkg::S_DONE;
          endcase
        end
      end
      chist_pkg::S_SCAN: begin
        if (hit_s || scan_end) begin
          state_d = chist_pkg::S_DONE;
        end
      end
      chist_pkg::S_READ: state_d = chist_pkg::S_DONE;
      chist_pkg::S_DONE: begin
        if (out_free) begin
          state_d = chist_pkg::S_IDLE;
        end
      end
      default: state_d = chist_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr    = scan_q;
    wr_addr    = chk_slot_q;
    color_we   = 1'b0;
    tally_we   = 1'b0;
    wr_color   = col_q;
    wr_tally   = sat_tally;
    res_d      = res_q;
    used_d     = used_q;
    scan_d     = scan_q;
    more_d     = more_q;
    chk_d      = 1'b0;
    chk_slot_d = chk_slot_q;
    add_new    = 1'b0;
    new_col    = col_q;
    case (state_q)
      chist_pkg::S_IDLE: begin
        rd_addr = chist_pkg::SLOT_W'(used_q - chist_pkg::USED_W'(1)
                                    - chist_pkg::USED_W'(in_data_i.position));
        new_col = in_col;
        if (acc) begin
          scan_d = chist_pkg::SLOT_W'(used_q - chist_pkg::USED_W'(1));
          more_d = 1'b1;
          res_d  = chist_pkg::make_rsp(1'b0, 1'b0, 8'd0, '0, '0, 9'(used_q));
          if ((in_data_i.req_type == chist_pkg::REQ_TALLY) && tbl_empty) begin
            add_new = 1'b1;
          end
        end
      end
      chist_pkg::S_SCAN: begin
        if (more_q) begin
          chk_d      = 1'b1;
          chk_slot_d = scan_q;
          if (scan_q == '0) begin
            more_d = 1'b0;
          end else begin
            scan_d = scan_q - chist_pkg::SLOT_W'(1);
          end
        end
        if (hit_s) begin
          if (req_q == chist_pkg::REQ_TALLY) begin
            tally_we = 1'b1;
            res_d = chist_pkg::make_rsp(1'b1, 1'b0, 8'(match_pos), col_q, sat_tally,
                                        9'(used_q));
          end else begin
            res_d = chist_pkg::make_rsp(1'b1, 1'b0, 8'(match_pos), rd_color_q, rd_tally_q,
                                        9'(used_q));
          end
        end else if (scan_end) begin
          res_d = chist_pkg::make_rsp(1'b0, 1'b0, 8'd0, '0, '0, 9'(used_q));
          if (req_q == chist_pkg::REQ_TALLY) begin
            add_new = 1'b1;
          end
        end
      end
      chist_pkg::S_READ: begin
        res_d = chist_pkg::make_rsp(1'b1, 1'b0, pos_q, rd_color_q, rd_tally_q, 9'(used_q));
      end
      chist_pkg::S_DONE: ;
      default: ;
    endcase
    if (add_new) begin
      if (32'(used_q) < chist_pkg::MAX_COLORS) begin
        wr_addr  = chist_pkg::SLOT_W'(used_q);
        wr_color = new_col;
        wr_tally = 32'd1;
        color_we = 1'b1;
        tally_we = 1'b1;
        used_d   = used_q + chist_pkg::USED_W'(1);
        res_d    = chist_pkg::make_rsp(1'b0, 1'b0, 8'd0, new_col, 32'd1, 9'(used_d));
      end else begin
        res_d = chist_pkg::make_rsp(1'b0, 1'b1, 8'd0, new_col, 32'd0, 9'(used_q));
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == chist_pkg::S_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (color_we) begin
      color_mem[wr_addr] <= wr_color;
    end
    if (tally_we) begin
      tally_mem[wr_addr] <= wr_tally;
    end
    rd_color_q <= color_mem[rd_addr];
    rd_tally_q <= tally_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chist_pkg::S_IDLE;
      used_q      <= '0;
      more_q      <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      more_q      <= more_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    chk_slot_q <= chk_slot_d;
    res_q      <= res_d;
    if (acc) begin
      req_q <= in_data_i.req_type;
      col_q <= in_col;
      pos_q <= in_data_i.position;
    end
    if ((state_q == chist_pkg::S_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= chist_pkg::MAX_COLORS)
    else $error("entry count beyond table depth");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + chist_pkg::USED_W'(1)))
    else $error("entry count moved by other than one");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == chist_pkg::S_DONE))
    else $error("output item without a finished result");

  a_chk_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == chist_pkg::S_SCAN) && chk_q) |-> (32'(chk_slot_q) < 32'(used_q)))
    else $error("scan checks a slot past the stored entries");

endmodule

`default_nettype wire
